/* src/spc_pkg.sv */
// Shared types and constants for the signal phase countdown block.
// Used by the top level, the pipelined remainder unit and the port checker.
// No dependencies.
`default_nettype none

package spc_pkg;

   localparam int TimeWidth     = 32;
   localparam int DvdWidth      = TimeWidth + 1;
   localparam int TotWidth      = 18;
   localparam int DurWidth      = 16;
   localparam int StepsPerStage = 3;
   localparam int DivStages     = (DvdWidth + StepsPerStage - 1) / StepsPerStage;

   localparam int CfgWidth      = 13;
   localparam int OffWidth      = 16;
   localparam int IndexWidth    = 8;
   localparam int CsrDataWidth  = 16;
   localparam int ReqDataWidth  = 32;
   localparam int RspDataWidth  = 80;

   localparam logic [IndexWidth-1:0] RegGreen  = 8'd0;
   localparam logic [IndexWidth-1:0] RegYellow = 8'd1;
   localparam logic [IndexWidth-1:0] RegRed    = 8'd2;
   localparam logic [IndexWidth-1:0] RegOffset = 8'd3;

   localparam logic [3:0] CodeGreen  = 4'd5;
   localparam logic [3:0] CodeYellow = 4'd7;
   localparam logic [3:0] CodeRed    = 4'd3;

   localparam logic [1:0] ColGreen  = 2'd0;
   localparam logic [1:0] ColYellow = 2'd1;
   localparam logic [1:0] ColRed    = 2'd2;

   typedef struct packed {
      logic [3:0]          light_code;
      logic                has_start;
      logic [TotWidth-1:0] start_in;
      logic [TotWidth-1:0] end_in;
      logic [TotWidth-1:0] next_start_in;
      logic [DurWidth-1:0] duration;
   } rec_type;

endpackage

`default_nettype wire

/* src/signal_phase_countdown_top.sv */
// Top level of the signal phase countdown block: config registers, cycle position
// pipeline, phase record computation and the record sequencer. Uses spc_pkg, spc_mod.
//
//   channel | direction | handshake            | contents
//   req     | in        | req_tvalid/tready    | tdata: now_tenths
//   rsp     | out       | rsp_tvalid/tready    | tdata: phase record, tuser: has_start
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A request passes through one offset add, eleven remainder stages of three
// bits each, one difference stage, the sequencer and the output register. The
// sequencer sends one record a cycle on the single result channel while the
// output is not stalled; an item gives one record per colour of non-zero
// duration (up to three). Reset is synchronous and clears the configuration
// registers and the valid bits; the pipeline holds as a whole while the
// sequencer has records left to send.
`default_nettype none

module signal_phase_countdown_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [spc_pkg::ReqDataWidth-1:0]    req_tdata,   // [31:0] now_tenths
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [3:0] light_code, [21:4] start_in, [39:22] end_in, [57:40] next_start_in,
   // [73:58] duration, [79:74] zero
   output logic [spc_pkg::RspDataWidth-1:0]         rsp_tdata,
   output logic                                     rsp_tuser,   // [0] has_start
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [spc_pkg::IndexWidth-1:0]      csr_index,
   input  wire logic [spc_pkg::CsrDataWidth-1:0]    csr_data
);

   localparam logic [spc_pkg::CfgWidth-1:0] ColourMax = 13'd6553;

   function automatic logic [spc_pkg::CfgWidth-1:0] clamp_colour(
      input logic [spc_pkg::CsrDataWidth-1:0] value
   );
      logic [spc_pkg::CfgWidth-1:0] v;
      v = value[spc_pkg::CfgWidth-1:0];
      return (v > ColourMax) ? ColourMax : v;
   endfunction

   function automatic logic [spc_pkg::DurWidth-1:0] times_ten(
      input logic [spc_pkg::CfgWidth-1:0] v
   );
      return {v, 3'b000} + {2'b00, v, 1'b0};
   endfunction

   function automatic logic [1:0] rotate(input logic [1:0] cur, input logic [1:0] k);
      logic [2:0] s;
      s = {1'b0, cur} + {1'b0, k};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   function automatic logic [3:0] colour_code(input logic [1:0] col);
      case (col)
         spc_pkg::ColGreen:  return spc_pkg::CodeGreen;
         spc_pkg::ColYellow: return spc_pkg::CodeYellow;
         default:            return spc_pkg::CodeRed;
      endcase
   endfunction

   // Configuration registers.
   logic [spc_pkg::CfgWidth-1:0] green_ff, yellow_ff, red_ff;
   logic [spc_pkg::OffWidth-1:0] offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff  <= '0;
         yellow_ff <= '0;
         red_ff    <= '0;
         offset_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            spc_pkg::RegGreen:  green_ff  <= clamp_colour(csr_data);
            spc_pkg::RegYellow: yellow_ff <= clamp_colour(csr_data);
            spc_pkg::RegRed:    red_ff    <= clamp_colour(csr_data);
            spc_pkg::RegOffset: offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Scaled cycle layout, refreshed every cycle from the registers.
   logic [spc_pkg::DurWidth-1:0] dur_ff [3];
   logic [spc_pkg::TotWidth-1:0] st_ff  [3];
   logic [spc_pkg::TotWidth-1:0] fin_ff [3];
   logic [spc_pkg::TotWidth-1:0] total_ff;
   logic [19:0]                  off10;

   // The offset is needed in the cycle a request is taken, so it comes straight
   // from its register.
   assign off10 = {offset_ff, 3'b000} + {3'b000, offset_ff, 1'b0};

   always_ff @(posedge clock) begin
      logic [spc_pkg::TotWidth-1:0] g, y, r;
      g = {2'b00, times_ten(green_ff)};
      y = {2'b00, times_ten(yellow_ff)};
      r = {2'b00, times_ten(red_ff)};
      dur_ff[0] <= g[spc_pkg::DurWidth-1:0];
      dur_ff[1] <= y[spc_pkg::DurWidth-1:0];
      dur_ff[2] <= r[spc_pkg::DurWidth-1:0];
      st_ff[0]  <= '0;
      st_ff[1]  <= g;
      st_ff[2]  <= g + y;
      fin_ff[0] <= g;
      fin_ff[1] <= g + y;
      fin_ff[2] <= g + y + r;
      total_ff  <= g + y + r;
   end

   // Sequencer and pipeline advance.
   logic                         adv;
   logic [2:0]                   em_pend_ff, em_pend_in, pend_after, sel_oh;
   logic [1:0]                   sel;
   spc_pkg::rec_type             em_rec_ff [3];
   spc_pkg::rec_type             em_rec_in [3];
   logic                         send;
   logic                         rsp_valid_ff;
   spc_pkg::rec_type             rsp_rec_ff;
   logic                         rsp_last_ff;

   always_comb begin
      if (em_pend_ff[0]) begin
         sel = 2'd0;
      end else if (em_pend_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      sel_oh     = 3'b001 << sel;
      send       = (|em_pend_ff) && (!rsp_valid_ff || rsp_tready);
      pend_after = send ? (em_pend_ff & ~sel_oh) : em_pend_ff;
      adv        = (pend_after == 3'b000);
   end

   assign req_tready = adv;

   // Offset stage.
   logic                         s0_valid_ff;
   logic [spc_pkg::DvdWidth-1:0] s0_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_t_ff <= {1'b0, req_tdata[spc_pkg::TimeWidth-1:0]}
                  + {13'b0, off10};
      end
   end

   // Cycle position by remainder.
   logic                         pos_valid;
   logic [spc_pkg::TotWidth-1:0] pos;

   spc_mod u_mod (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s0_valid_ff),
      .in_dividend (s0_t_ff),
      .divisor     (total_ff),
      .out_valid   (pos_valid),
      .out_rem     (pos)
   );

   // Difference stage: signed offsets of each colour's start and end from the position.
   logic               a_valid_ff;
   logic [1:0]         a_cur_ff;
   logic [2:0]         a_has_ff;
   logic signed [18:0] a_nsd_ff [3];
   logic signed [18:0] a_end_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= pos_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            a_nsd_ff[c] <= $signed({1'b0, st_ff[c]}) - $signed({1'b0, pos});
            a_end_ff[c] <= $signed({1'b0, fin_ff[c]}) - $signed({1'b0, pos});
            a_has_ff[c] <= (pos < st_ff[c]) || (pos > fin_ff[c]);
         end
         if (pos < fin_ff[0]) begin
            a_cur_ff <= spc_pkg::ColGreen;
         end else if (pos < fin_ff[1]) begin
            a_cur_ff <= spc_pkg::ColYellow;
         end else begin
            a_cur_ff <= spc_pkg::ColRed;
         end
      end
   end

   // Wrap the differences into the cycle and order the records from the current colour.
   always_comb begin
      spc_pkg::rec_type   col_rec [3];
      logic signed [18:0] tot_s;
      logic signed [18:0] ns_s, en_s;
      logic [1:0]         idx;
      tot_s = $signed({1'b0, total_ff});
      ns_s  = '0;
      en_s  = '0;
      idx   = '0;
      for (int c = 0; c < 3; c++) begin
         ns_s = (a_nsd_ff[c] < 0) ? a_nsd_ff[c] + tot_s : a_nsd_ff[c];
         if (a_end_ff[c] < 0) begin
            en_s = a_end_ff[c] + tot_s;
         end else if (a_end_ff[c] >= tot_s) begin
            en_s = a_end_ff[c] - tot_s;
         end else begin
            en_s = a_end_ff[c];
         end
         col_rec[c].light_code    = colour_code(2'(c));
         col_rec[c].has_start     = a_has_ff[c];
         col_rec[c].start_in      = a_has_ff[c] ? ns_s[spc_pkg::TotWidth-1:0] : '0;
         col_rec[c].end_in        = en_s[spc_pkg::TotWidth-1:0];
         col_rec[c].next_start_in = ns_s[spc_pkg::TotWidth-1:0];
         col_rec[c].duration      = dur_ff[c];
      end
      for (int k = 0; k < 3; k++) begin
         idx           = rotate(a_cur_ff, 2'(k));
         em_rec_in[k]  = col_rec[idx];
         em_pend_in[k] = a_valid_ff && (dur_ff[idx] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_pend_ff <= '0;
      end else if (adv) begin
         em_pend_ff <= em_pend_in;
      end else begin
         em_pend_ff <= pend_after;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         em_rec_ff <= em_rec_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         rsp_rec_ff  <= em_rec_ff[sel];
         rsp_last_ff <= ((em_pend_ff & ~sel_oh) == 3'b000);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_rec_ff.duration, rsp_rec_ff.next_start_in,
                        rsp_rec_ff.end_in, rsp_rec_ff.start_in, rsp_rec_ff.light_code};
   assign rsp_tuser  = rsp_rec_ff.has_start;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* src/spc_mod.sv */
// Pipelined remainder unit: restoring long division, a few dividend bits per stage.
// Depends on spc_pkg for widths and the stage count.
`default_nettype none

module spc_mod (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [spc_pkg::DvdWidth-1:0]    in_dividend,
   input  wire logic [spc_pkg::TotWidth-1:0]    divisor,
   output logic                                 out_valid,
   output logic [spc_pkg::TotWidth-1:0]         out_rem
);

   logic [spc_pkg::DivStages-1:0] vld_ff;
   logic [spc_pkg::DivStages-1:0] vld_in;
   logic [spc_pkg::TotWidth-1:0]  rem_ff [spc_pkg::DivStages];
   logic [spc_pkg::TotWidth-1:0]  rem_in [spc_pkg::DivStages];
   logic [spc_pkg::DvdWidth-1:0]  dvd_ff [spc_pkg::DivStages];
   logic [spc_pkg::DvdWidth-1:0]  dvd_in [spc_pkg::DivStages];

   always_comb begin
      logic [spc_pkg::TotWidth:0]   r19;
      logic [spc_pkg::TotWidth-1:0] r;
      logic [spc_pkg::DvdWidth-1:0] d;
      r19 = '0;
      r   = '0;
      d   = '0;
      for (int k = 0; k < spc_pkg::DivStages; k++) begin
         if (k == 0) begin
            vld_in[k] = in_valid;
            r         = '0;
            d         = in_dividend;
         end else begin
            vld_in[k] = vld_ff[k-1];
            r         = rem_ff[k-1];
            d         = dvd_ff[k-1];
         end
         // Each step brings down the next dividend bit; the partial remainder
         // stays below the divisor, so one conditional subtract suffices.
         for (int i = 0; i < spc_pkg::StepsPerStage; i++) begin
            if (k * spc_pkg::StepsPerStage + i < spc_pkg::DvdWidth) begin
               r19 = {r, d[spc_pkg::DvdWidth-1]};
               d   = {d[spc_pkg::DvdWidth-2:0], 1'b0};
               if (r19 >= {1'b0, divisor}) begin
                  r19 = r19 - {1'b0, divisor};
               end
               r = r19[spc_pkg::TotWidth-1:0];
            end
         end
         rem_in[k] = r;
         dvd_in[k] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < spc_pkg::DivStages; k++) begin
            rem_ff[k] <= rem_in[k];
            dvd_ff[k] <= dvd_in[k];
         end
      end
   end

   assign out_valid = vld_ff[spc_pkg::DivStages-1];
   assign out_rem   = rem_ff[spc_pkg::DivStages-1];

endmodule

`default_nettype wire

/* src/spc_checker.sv */
// Port-level checker for the signal phase countdown top level, bound to it below.
// Depends on spc_pkg for widths and light codes.
`default_nettype none

module spc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [spc_pkg::ReqDataWidth-1:0]  req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [spc_pkg::RspDataWidth-1:0]  rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tlast,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready,
   input wire logic [spc_pkg::IndexWidth-1:0]    csr_index,
   input wire logic [spc_pkg::CsrDataWidth-1:0]  csr_data
);

   logic [3:0]  code;
   logic [17:0] start_in, next_start_in;

   assign code          = rsp_tdata[3:0];
   assign start_in      = rsp_tdata[21:4];
   assign next_start_in = rsp_tdata[57:40];

   // The output register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled record keeps its payload and its frame marker.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled record changed");

   // Every record carries one of the three light codes.
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (code == spc_pkg::CodeGreen || code == spc_pkg::CodeYellow
                      || code == spc_pkg::CodeRed))
      else $error("unknown light code");

   // The start time is the next start when flagged, and zero otherwise.
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser ? (start_in == next_start_in) : (start_in == '0)))
      else $error("start time does not match its flag");

endmodule

bind signal_phase_countdown_top spc_checker u_spc_checker (.*);

`default_nettype wire
